[rtl/fcca_pkg.sv]
`default_nettype none

package fcca_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int ENTRY_W       = 32;
  localparam int LINK_W        = 28;
  localparam int MAX_CHAIN     = 64;
  localparam int LEN_W         = 7;
  localparam int CHAIN_AW      = $clog2(MAX_CHAIN);

  localparam logic [ENTRY_W-1:0] EOC_MARK   = 32'h0FFF_FFF8;
  localparam logic [LINK_W-1:0]  EOC_LINK   = 28'hFFF_FFF8;
  localparam logic [ENTRY_W-1:0] RSVD0_INIT = 32'hFFFF_FFF8;
  localparam logic [ENTRY_W-1:0] RSVD1_INIT = 32'h0FFF_FFFF;
  localparam logic [IDX_W-1:0]   CNT_MAX    = {IDX_W{1'b1}};
  localparam logic [IDX_W-1:0]   FIRST_DATA = IDX_W'(2);
  localparam logic [IDX_W-1:0]   COUNT_INIT = IDX_W'(4094);

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_REWRITE = 2'd1;
  localparam logic [1:0] OP_LINK    = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [LEN_W-1:0] chain_length;
    logic [IDX_W-1:0] start_cluster;
    logic [31:0]      link_value;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   cluster;
    logic               last;
    logic [1:0]         status;
    logic [ENTRY_W-1:0] entry_value;
    logic [IDX_W-1:0]   free_clusters;
    logic [IDX_W-1:0]   last_allocated;
  } rsp_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [ENTRY_W-1:0] data;
  } tbl_wr_t;

  // Highest valid data index: cluster_count plus one, held to the last table index.
  function automatic logic [IDX_W-1:0] top_index(input logic [IDX_W-1:0] cc);
    return (cc == CNT_MAX) ? CNT_MAX : cc + IDX_W'(1);
  endfunction

  function automatic logic is_data(input logic [IDX_W-1:0] x, input logic [IDX_W-1:0] top);
    return (x >= FIRST_DATA) && (x <= top);
  endfunction

  function automatic logic [IDX_W-1:0] free_count(input logic [IDX_W-1:0] cc,
                                                  input logic [IDX_W-1:0] total);
    return (cc > total) ? cc - total : '0;
  endfunction

endpackage

`default_nettype wire

[rtl/fcca_table.sv]
`default_nettype none

module fcca_table (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire fcca_pkg::tbl_wr_t             wr,
  input  wire logic [fcca_pkg::IDX_W-1:0]    rd_addr,
  output logic      [fcca_pkg::ENTRY_W-1:0]  rd_data,
  output logic                               busy
);

  logic [fcca_pkg::ENTRY_W-1:0] mem [fcca_pkg::TABLE_ENTRIES];
  logic [fcca_pkg::IDX_W-1:0]   clr_ptr;
  logic                         clearing;
  logic [fcca_pkg::ENTRY_W-1:0] init_value;

  // The two reserved entries get their marks; every other entry reads as free.
  always_comb begin
    if (clr_ptr == '0) begin
      init_value = fcca_pkg::RSVD0_INIT;
    end else if (clr_ptr == fcca_pkg::IDX_W'(1)) begin
      init_value = fcca_pkg::RSVD1_INIT;
    end else begin
      init_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_ptr  <= '0;
    end else if (clearing) begin
      clr_ptr <= clr_ptr + fcca_pkg::IDX_W'(1);
      if (clr_ptr == fcca_pkg::IDX_W'(fcca_pkg::TABLE_ENTRIES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_ptr] <= init_value;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

  assign busy = clearing;

endmodule

`default_nettype wire

[rtl/fat_cluster_chain_allocator_unit.sv]
// Cluster chain allocator with a 4096-entry cluster table.
// Requests arrive on req (valid/ready) and each gives one or more items on rsp
// (valid/ready): allocate and rewrite give one item per chain cluster followed,
// on failure, by an error item; link and read give exactly one. The final item
// of a request has last set. cfg_wr_en writes cluster_count at any time, but it
// should only change while the block is idle.
// After reset the table is swept one entry per cycle, all 4096 entries, with
// req_ready low; the reserved entries 0 and 1 get their marks and the rest
// are cleared.
// Throughput is one request at a time.
// Allocate and rewrite step each chain cluster through read, update, link
// (skipped for the first) and next states, plus the free search, which
// examines one table entry per cycle through the single read port, plus
// read, fetch and output states per item emitted and an error state for an
// error item. All table traffic shares one read port and one write port.
// Items leave through an output register; if the receiver stalls, the block
// holds the pending item and waits, and the next request can already be taken
// once the last item of the current one sits in that register.
`default_nettype none

module fat_cluster_chain_allocator_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire fcca_pkg::req_t              req,
  output logic                             rsp_valid,
  input  wire logic                        rsp_ready,
  output fcca_pkg::rsp_t                   rsp,
  input  wire logic                        cfg_wr_en,
  input  wire logic [fcca_pkg::IDX_W-1:0]  cfg_wr_data
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_SCAN   = 14'b00000000000010,
    S_C_RD   = 14'b00000000000100,
    S_C_UPD  = 14'b00000000001000,
    S_C_LINK = 14'b00000000010000,
    S_C_NEXT = 14'b00000000100000,
    S_L_RD   = 14'b00000001000000,
    S_L_WR   = 14'b00000010000000,
    S_R_RD   = 14'b00000100000000,
    S_R_OUT  = 14'b00001000000000,
    S_E_RDU  = 14'b00010000000000,
    S_E_RDT  = 14'b00100000000000,
    S_E_OUT  = 14'b01000000000000,
    S_E_ERR  = 14'b10000000000000
  } state_t;

  state_t state;

  logic [1:0]                    op;
  logic [fcca_pkg::LEN_W-1:0]    len;
  logic [fcca_pkg::IDX_W-1:0]    start;
  logic [fcca_pkg::ENTRY_W-1:0]  link_val;
  logic [fcca_pkg::IDX_W-1:0]    cur;
  logic [fcca_pkg::IDX_W-1:0]    prev;
  logic [fcca_pkg::ENTRY_W-1:0]  cur_val;
  logic [fcca_pkg::LEN_W-1:0]    n;
  logic [fcca_pkg::LEN_W-1:0]    k;
  logic [1:0]                    err;
  logic [fcca_pkg::IDX_W-1:0]    errcl;
  logic [fcca_pkg::IDX_W-1:0]    scan_ptr;
  logic [fcca_pkg::IDX_W-1:0]    scan_left;
  logic                          chk_valid;
  logic [fcca_pkg::IDX_W-1:0]    chk_addr;
  logic [fcca_pkg::IDX_W-1:0]    last_alloc;
  logic [fcca_pkg::IDX_W-1:0]    total;
  logic [fcca_pkg::IDX_W-1:0]    cluster_count;

  logic [fcca_pkg::IDX_W-1:0]    used_mem [fcca_pkg::MAX_CHAIN];
  logic [fcca_pkg::IDX_W-1:0]    used_q;

  fcca_pkg::tbl_wr_t             tbl_wr;
  logic [fcca_pkg::IDX_W-1:0]    rd_addr;
  logic [fcca_pkg::ENTRY_W-1:0]  rd_data;
  logic                          tbl_busy;

  logic [fcca_pkg::IDX_W-1:0]    top;
  logic [fcca_pkg::IDX_W-1:0]    scan_from;
  logic [fcca_pkg::IDX_W-1:0]    scan_ptr0;
  logic [fcca_pkg::IDX_W-1:0]    scan_left0;
  logic [fcca_pkg::LEN_W-1:0]    len_clamp;
  logic [fcca_pkg::LINK_W-1:0]   next_link;
  logic                          follow_end;
  logic                          next_ok;
  logic [fcca_pkg::IDX_W-1:0]    total_link;
  logic                          slot_free;
  logic                          rsp_load;
  logic [fcca_pkg::LEN_W-1:0]    k_inc;

  fcca_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (tbl_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (tbl_busy)
  );

  assign top        = fcca_pkg::top_index(cluster_count);
  assign scan_from  = (last_alloc < fcca_pkg::FIRST_DATA) ? fcca_pkg::FIRST_DATA : last_alloc;
  assign scan_ptr0  = (scan_from > top) ? fcca_pkg::FIRST_DATA : scan_from;
  // The data area holds top-1 clusters, none when top is below the first data index.
  assign scan_left0 = top - fcca_pkg::IDX_W'(1);

  assign len_clamp = (req.chain_length == '0) ? fcca_pkg::LEN_W'(1) :
                     (req.chain_length > fcca_pkg::LEN_W'(fcca_pkg::MAX_CHAIN)) ?
                     fcca_pkg::LEN_W'(fcca_pkg::MAX_CHAIN) : req.chain_length;

  // Allocate always searches afresh; rewrite follows the stored link.
  assign next_link  = (op == fcca_pkg::OP_REWRITE) ? cur_val[fcca_pkg::LINK_W-1:0] : '0;
  assign follow_end = (next_link == '0) || (next_link >= fcca_pkg::EOC_LINK);
  assign next_ok    = (next_link[fcca_pkg::LINK_W-1:fcca_pkg::IDX_W] == '0) &&
                      fcca_pkg::is_data(next_link[fcca_pkg::IDX_W-1:0], top);

  always_comb begin
    total_link = total;
    if ((rd_data == '0) && (link_val != '0)) begin
      if (total != fcca_pkg::CNT_MAX) begin
        total_link = total + fcca_pkg::IDX_W'(1);
      end
    end else if ((rd_data != '0) && (link_val == '0)) begin
      if (total != '0) begin
        total_link = total - fcca_pkg::IDX_W'(1);
      end
    end
  end

  assign slot_free = !rsp_valid || rsp_ready;
  assign rsp_load  = slot_free &&
                     (state inside {S_L_WR, S_R_OUT, S_E_OUT, S_E_ERR});
  assign req_ready = (state == S_IDLE) && !tbl_busy;
  assign k_inc     = k + fcca_pkg::LEN_W'(1);

  always_comb begin
    case (state)
      S_SCAN:                            rd_addr = scan_ptr;
      S_L_RD, S_L_WR, S_R_RD, S_R_OUT:   rd_addr = start;
      S_E_RDT, S_E_OUT:                  rd_addr = used_q;
      default:                           rd_addr = cur;
    endcase
  end

  always_comb begin
    tbl_wr      = '0;
    tbl_wr.addr = cur;
    case (state)
      S_C_UPD: begin
        tbl_wr.en   = (rd_data == '0);
        tbl_wr.data = fcca_pkg::EOC_MARK;
      end
      S_C_LINK: begin
        tbl_wr.en   = 1'b1;
        tbl_wr.addr = prev;
        tbl_wr.data = {{(fcca_pkg::ENTRY_W-fcca_pkg::IDX_W){1'b0}}, cur};
      end
      S_L_WR: begin
        tbl_wr.en   = slot_free;
        tbl_wr.addr = start;
        tbl_wr.data = link_val;
      end
      default: begin
        tbl_wr.en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_C_UPD) begin
      used_mem[n[fcca_pkg::CHAIN_AW-1:0]] <= cur;
    end
    used_q <= used_mem[k[fcca_pkg::CHAIN_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rsp_valid     <= 1'b0;
      chk_valid     <= 1'b0;
      last_alloc    <= fcca_pkg::IDX_W'(1);
      total         <= '0;
      cluster_count <= fcca_pkg::COUNT_INIT;
    end else begin
      if (cfg_wr_en) begin
        cluster_count <= cfg_wr_data;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            op       <= req.opcode;
            len      <= len_clamp;
            start    <= req.start_cluster;
            link_val <= req.link_value;
            n        <= '0;
            k        <= '0;
            err      <= fcca_pkg::ST_OK;
            errcl    <= '0;
            case (req.opcode)
              fcca_pkg::OP_ALLOC: begin
                scan_ptr  <= scan_ptr0;
                scan_left <= scan_left0;
                chk_valid <= 1'b0;
                state     <= S_SCAN;
              end
              fcca_pkg::OP_REWRITE: begin
                if (fcca_pkg::is_data(req.start_cluster, top)) begin
                  cur   <= req.start_cluster;
                  state <= S_C_RD;
                end else begin
                  err   <= fcca_pkg::ST_RANGE;
                  errcl <= req.start_cluster;
                  state <= S_E_ERR;
                end
              end
              fcca_pkg::OP_LINK: begin
                if (fcca_pkg::is_data(req.start_cluster, top)) begin
                  state <= S_L_RD;
                end else begin
                  err   <= fcca_pkg::ST_RANGE;
                  errcl <= req.start_cluster;
                  state <= S_E_ERR;
                end
              end
              default: begin
                if (req.start_cluster <= top) begin
                  state <= S_R_RD;
                end else begin
                  err   <= fcca_pkg::ST_RANGE;
                  errcl <= req.start_cluster;
                  state <= S_E_ERR;
                end
              end
            endcase
          end
        end

        // One entry is fetched per cycle; the compare tests the registered read data of the entry held in chk_addr.
        S_SCAN: begin
          if (chk_valid && (rd_data == '0)) begin
            cur   <= chk_addr;
            state <= S_C_RD;
          end else if (scan_left != '0) begin
            chk_valid <= 1'b1;
            chk_addr  <= scan_ptr;
            scan_ptr  <= (scan_ptr == top) ? fcca_pkg::FIRST_DATA :
                         scan_ptr + fcca_pkg::IDX_W'(1);
            scan_left <= scan_left - fcca_pkg::IDX_W'(1);
          end else begin
            chk_valid <= 1'b0;
            err       <= fcca_pkg::ST_NO_SPACE;
            errcl     <= '0;
            state     <= (n == '0) ? S_E_ERR : S_E_RDU;
          end
        end

        S_C_RD: begin
          state <= S_C_UPD;
        end

        S_C_UPD: begin
          if (rd_data == '0) begin
            cur_val    <= fcca_pkg::EOC_MARK;
            last_alloc <= cur;
            if (total != fcca_pkg::CNT_MAX) begin
              total <= total + fcca_pkg::IDX_W'(1);
            end
          end else begin
            cur_val <= rd_data;
          end
          n     <= n + fcca_pkg::LEN_W'(1);
          state <= (n != '0) ? S_C_LINK : S_C_NEXT;
        end

        // A chain that loops back onto itself sees its own link just written.
        S_C_LINK: begin
          if (prev == cur) begin
            cur_val <= {{(fcca_pkg::ENTRY_W-fcca_pkg::IDX_W){1'b0}}, cur};
          end
          state <= S_C_NEXT;
        end

        S_C_NEXT: begin
          prev <= cur;
          if (n >= len) begin
            state <= S_E_RDU;
          end else if (follow_end) begin
            scan_ptr  <= scan_ptr0;
            scan_left <= scan_left0;
            chk_valid <= 1'b0;
            state     <= S_SCAN;
          end else if (!next_ok) begin
            err   <= fcca_pkg::ST_RANGE;
            errcl <= next_link[fcca_pkg::IDX_W-1:0];
            state <= S_E_RDU;
          end else begin
            cur   <= next_link[fcca_pkg::IDX_W-1:0];
            state <= S_C_RD;
          end
        end

        S_L_RD: begin
          state <= S_L_WR;
        end

        S_L_WR: begin
          if (slot_free) begin
            total              <= total_link;
            rsp.cluster        <= start;
            rsp.last           <= 1'b1;
            rsp.status         <= fcca_pkg::ST_OK;
            rsp.entry_value    <= link_val;
            rsp.free_clusters  <= fcca_pkg::free_count(cluster_count, total_link);
            rsp.last_allocated <= last_alloc;
            state              <= S_IDLE;
          end
        end

        S_R_RD: begin
          state <= S_R_OUT;
        end

        S_R_OUT: begin
          if (slot_free) begin
            rsp.cluster        <= start;
            rsp.last           <= 1'b1;
            rsp.status         <= fcca_pkg::ST_OK;
            rsp.entry_value    <= rd_data;
            rsp.free_clusters  <= fcca_pkg::free_count(cluster_count, total);
            rsp.last_allocated <= last_alloc;
            state              <= S_IDLE;
          end
        end

        S_E_RDU: begin
          state <= S_E_RDT;
        end

        S_E_RDT: begin
          state <= S_E_OUT;
        end

        S_E_OUT: begin
          if (slot_free) begin
            rsp.cluster        <= used_q;
            rsp.last           <= (k_inc == n) && (err == fcca_pkg::ST_OK);
            rsp.status         <= fcca_pkg::ST_OK;
            rsp.entry_value    <= rd_data;
            rsp.free_clusters  <= fcca_pkg::free_count(cluster_count, total);
            rsp.last_allocated <= last_alloc;
            k                  <= k_inc;
            if (k_inc == n) begin
              state <= (err != fcca_pkg::ST_OK) ? S_E_ERR : S_IDLE;
            end else begin
              state <= S_E_RDU;
            end
          end
        end

        S_E_ERR: begin
          if (slot_free) begin
            rsp.cluster        <= errcl;
            rsp.last           <= 1'b1;
            rsp.status         <= err;
            rsp.entry_value    <= '0;
            rsp.free_clusters  <= fcca_pkg::free_count(cluster_count, total);
            rsp.last_allocated <= last_alloc;
            state              <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/fcca_checker.sv]
`default_nettype none

module fcca_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            req_valid,
  input wire logic            req_ready,
  input wire logic            rsp_valid,
  input wire logic            rsp_ready,
  input wire fcca_pkg::rsp_t  rsp
);

  // A stalled item stays on the port unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response item changed or dropped while stalled");

  // An error always ends its request.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != fcca_pkg::ST_OK) |-> rsp.last)
    else $error("error item without last");

  a_err_body: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != fcca_pkg::ST_OK) |->
      (rsp.entry_value == '0) &&
      ((rsp.status == fcca_pkg::ST_RANGE) ||
       ((rsp.status == fcca_pkg::ST_NO_SPACE) && (rsp.cluster == '0))))
    else $error("malformed error item");

  // Requests are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

  // The table sweep after reset keeps the request channel closed.
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("request channel open straight after reset");

endmodule

bind fat_cluster_chain_allocator_unit fcca_checker u_fcca_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire

[test/fat_cluster_chain_allocator_unit_tb.sv]
`timescale 1ns / 1ps

module fat_cluster_chain_allocator_unit_tb;
  import fcca_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam int unsigned LONG_HOLD   = 600;
  localparam int unsigned MAX_PRINTED = 40;

  // Mirror of the cluster table and its counters; it predicts the items of each
  // accepted request and checks the items that come back, oldest first.
  class fat_shadow;
    logic [ENTRY_W-1:0] fat [TABLE_ENTRIES];
    int unsigned        origin;
    int unsigned        used_total;
    int unsigned        count;
    rsp_t               expected_q [$];
    logic [IDX_W-1:0]   chain_heads [$];
    int unsigned        mismatches;
    int unsigned        checked;

    function new();
      foreach (fat[i]) fat[i] = '0;
      fat[0]      = RSVD0_INIT;
      fat[1]      = RSVD1_INIT;
      origin      = 1;
      used_total  = 0;
      count       = COUNT_INIT;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function int unsigned top_cluster();
      int unsigned t;
      t = count + 1;
      if (t > TABLE_ENTRIES - 1) t = TABLE_ENTRIES - 1;
      return t;
    endfunction

    function bit in_data(int unsigned i);
      return i >= 2 && i <= top_cluster();
    endfunction

    // Next-fit: from the last cluster taken up to the top, then wrap to 2.
    function int unsigned next_free();
      int unsigned top;
      int unsigned from;
      int unsigned i;
      top  = top_cluster();
      from = (origin < 2) ? 2 : origin;
      for (i = from; i <= top; i++)
        if (fat[i] == '0) return i;
      for (i = 2; i < from && i <= top; i++)
        if (fat[i] == '0) return i;
      return 0;
    endfunction

    function void claim(int unsigned c);
      fat[c] = EOC_MARK;
      origin = c & 12'hFFF;
      if (used_total < 4095) used_total++;
    endfunction

    function void push_result(int unsigned cl, bit fin, logic [1:0] st,
                              logic [ENTRY_W-1:0] ev);
      rsp_t e;
      e.cluster        = IDX_W'(cl);
      e.last           = fin;
      e.status         = st;
      e.entry_value    = ev;
      e.free_clusters  = (count > used_total) ? IDX_W'(count - used_total) : '0;
      e.last_allocated = IDX_W'(origin);
      expected_q.push_back(e);
    endfunction

    function void note_request(req_t r);
      int unsigned len;
      int unsigned start;
      int unsigned cur;
      int unsigned prev;
      int unsigned nxt;
      int unsigned errcl;
      int unsigned i;
      int unsigned chain [$];
      logic [1:0]  err;
      bit          have_prev;
      len   = r.chain_length;
      start = r.start_cluster;
      if (r.opcode == OP_ALLOC || r.opcode == OP_REWRITE) begin
        if (len == 0) len = 1;
        if (len > MAX_CHAIN) len = MAX_CHAIN;
        err       = ST_OK;
        errcl     = 0;
        cur       = 0;
        prev      = 0;
        have_prev = 1'b0;
        if (r.opcode == OP_ALLOC) begin
          cur = next_free();
          if (cur == 0) err = ST_NO_SPACE;
        end else if (!in_data(start)) begin
          err   = ST_RANGE;
          errcl = start;
        end else begin
          cur = start;
        end
        for (i = 0; i < len && err == ST_OK; i++) begin
          if (fat[cur] == '0) claim(cur);
          if (have_prev) fat[prev] = cur;
          chain.push_back(cur);
          if (i + 1 < len) begin
            nxt       = (r.opcode == OP_REWRITE) ? fat[cur][LINK_W-1:0] : 0;
            prev      = cur;
            have_prev = 1'b1;
            // A zero link or an end-of-chain mark means the chain ends here.
            if (nxt == 0 || nxt >= EOC_LINK) begin
              nxt = next_free();
              if (nxt == 0) begin
                err = ST_NO_SPACE;
                break;
              end
            end else if (!in_data(nxt)) begin
              err   = ST_RANGE;
              errcl = nxt & 12'hFFF;
              break;
            end
            cur = nxt;
          end
        end
        foreach (chain[k])
          push_result(chain[k], k == chain.size() - 1 && err == ST_OK, ST_OK, fat[chain[k]]);
        if (err != ST_OK) push_result(errcl, 1'b1, err, '0);
        if (r.opcode == OP_ALLOC && chain.size() != 0) begin
          chain_heads.push_back(IDX_W'(chain[0]));
          if (chain_heads.size() > 64) void'(chain_heads.pop_front());
        end
      end else if (r.opcode == OP_LINK) begin
        if (!in_data(start)) begin
          push_result(start, 1'b1, ST_RANGE, '0);
        end else begin
          if (fat[start] == '0 && r.link_value != '0) begin
            if (used_total < 4095) used_total++;
          end else if (fat[start] != '0 && r.link_value == '0) begin
            if (used_total > 0) used_total--;
          end
          fat[start] = r.link_value;
          push_result(start, 1'b1, ST_OK, r.link_value);
        end
      end else begin
        if (start > top_cluster()) push_result(start, 1'b1, ST_RANGE, '0);
        else push_result(start, 1'b1, ST_OK, fat[start]);
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_item(rsp_t got);
      rsp_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("item %0d not expected (cluster %0d, status %0d)",
                                  checked, got.cluster, got.status));
        return;
      end
      want = expected_q.pop_front();
      if (got.cluster !== want.cluster)
        report_mismatch($sformatf("item %0d cluster %0d, expected %0d",
                                  checked, got.cluster, want.cluster));
      if (got.last !== want.last)
        report_mismatch($sformatf("item %0d last %b, expected %b",
                                  checked, got.last, want.last));
      if (got.status !== want.status)
        report_mismatch($sformatf("item %0d status %0d, expected %0d",
                                  checked, got.status, want.status));
      if (got.entry_value !== want.entry_value)
        report_mismatch($sformatf("item %0d entry_value %h, expected %h",
                                  checked, got.entry_value, want.entry_value));
      if (got.free_clusters !== want.free_clusters)
        report_mismatch($sformatf("item %0d free_clusters %0d, expected %0d",
                                  checked, got.free_clusters, want.free_clusters));
      if (got.last_allocated !== want.last_allocated)
        report_mismatch($sformatf("item %0d last_allocated %0d, expected %0d",
                                  checked, got.last_allocated, want.last_allocated));
    endtask
  endclass

  logic             clk;
  logic             rst         = 1'b1;
  logic             req_valid   = 1'b0;
  logic             req_ready;
  req_t             req         = '0;
  logic             rsp_valid;
  logic             rsp_ready   = 1'b0;
  rsp_t             rsp;
  logic             cfg_wr_en   = 1'b0;
  logic [IDX_W-1:0] cfg_wr_data = '0;
  int unsigned      cycle_count = 0;
  fat_shadow        shadow;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  fat_cluster_chain_allocator_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  function automatic int unsigned sender_pause();
    int unsigned s;
    s = $urandom_range(0, 99);
    if (s < 70) return 0;
    if (s < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  // Short chains keep the free search cheap when the table is large.
  function automatic int unsigned pick_length(bit short_chains);
    int unsigned s;
    s = $urandom_range(0, 99);
    if (s < 5) return 0;
    if (short_chains || s < 70) return $urandom_range(1, 8);
    if (s < 85) return $urandom_range(9, 64);
    if (s < 92) return MAX_CHAIN;
    return $urandom_range(65, 127);
  endfunction

  function automatic req_t random_request(bit short_chains);
    req_t        r;
    int unsigned pick;
    int unsigned s;
    int unsigned top;
    top             = shadow.top_cluster();
    pick            = $urandom_range(0, 99);
    s               = $urandom_range(0, 99);
    r.opcode        = OP_READ;
    r.chain_length  = LEN_W'($urandom_range(0, 127));
    r.start_cluster = IDX_W'($urandom);
    r.link_value    = $urandom;
    if (pick < 35) begin
      r.opcode       = OP_ALLOC;
      r.chain_length = LEN_W'(pick_length(short_chains));
    end else if (pick < 60) begin
      r.opcode       = OP_REWRITE;
      r.chain_length = LEN_W'(pick_length(short_chains));
      // Mostly follow chains that were really built, so the walk goes deep.
      if (s < 75 && shadow.chain_heads.size() != 0)
        r.start_cluster = shadow.chain_heads[$urandom_range(0, shadow.chain_heads.size() - 1)];
      else if (s < 90)
        r.start_cluster = IDX_W'($urandom_range(2, top));
    end else if (pick < 78) begin
      r.opcode = OP_LINK;
      if (s < 85) r.start_cluster = IDX_W'($urandom_range(2, top));
      s = $urandom_range(0, 99);
      if (s < 30) r.link_value = '0;
      else if (s < 55) r.link_value = $urandom_range(2, top);
      else if (s < 65) r.link_value = {4'($urandom), EOC_LINK + LINK_W'($urandom_range(0, 7))};
      else if (s < 75) r.link_value = $urandom & 32'hF000_0000;
    end else begin
      if (s < 80) r.start_cluster = IDX_W'($urandom_range(0, top));
    end
    return r;
  endfunction

  task automatic hold_sender(int unsigned n);
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_req(req_t r);
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_ready !== 1'b1);
    shadow.note_request(r);
    hold_sender(sender_pause());
  endtask

  task automatic send_op(logic [1:0] op, int unsigned len, int unsigned start,
                         logic [31:0] val);
    req_t r;
    r.opcode        = op;
    r.chain_length  = LEN_W'(len);
    r.start_cluster = IDX_W'(start);
    r.link_value    = val;
    send_req(r);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (shadow.expected_q.size() != 0) @(posedge clk);
  endtask

  // The register is only changed once every outstanding item has come back.
  task automatic set_cluster_count(int unsigned v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= IDX_W'(v);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow.count = v;
  endtask

  task automatic run_random(int unsigned n, bit short_chains);
    repeat (n) send_req(random_request(short_chains));
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("fat_cluster_chain_allocator_unit test failed");
    $finish;
  end

  initial begin
    int unsigned wait_left;
    int unsigned taken;
    int unsigned s;
    wait_left = 0;
    taken     = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid === 1'b1 && rsp_ready) begin
        shadow.check_item(rsp);
        taken++;
        s = $urandom_range(0, 99);
        // Two long hold-offs let the block fill up while requests keep coming.
        if (taken == 400 || taken == 1500) wait_left = LONG_HOLD;
        else if ((taken / 150) % 3 == 2 || s < 70) wait_left = 0;
        else if (s < 95) wait_left = $urandom_range(1, 3);
        else wait_left = $urandom_range(15, 60);
      end else if (wait_left != 0) begin
        wait_left--;
      end
      rsp_ready <= (wait_left == 0);
    end
  end

  initial begin
    shadow = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset value of the register: reserved entries, chain ends and bad links.
    send_op(OP_READ, 1, 0, $urandom);
    send_op(OP_READ, 1, 1, $urandom);
    send_op(OP_READ, 1, 4095, $urandom);
    send_op(OP_ALLOC, 1, $urandom_range(0, 4095), $urandom);
    send_op(OP_ALLOC, 0, $urandom_range(0, 4095), $urandom);
    send_op(OP_ALLOC, 3, $urandom_range(0, 4095), $urandom);
    send_op(OP_ALLOC, 64, $urandom_range(0, 4095), $urandom);
    send_op(OP_ALLOC, 127, $urandom_range(0, 4095), $urandom);
    send_op(OP_REWRITE, 6, 4, $urandom);
    send_op(OP_REWRITE, 2, 0, $urandom);
    send_op(OP_REWRITE, 2, 1, $urandom);
    send_op(OP_REWRITE, 2, 4095, $urandom);
    send_op(OP_LINK, 1, 0, 32'd5);
    send_op(OP_LINK, 1, 1, 32'd5);
    send_op(OP_LINK, 1, 4095, 32'd0);
    send_op(OP_LINK, 1, 5, 32'h0000_1000);
    send_op(OP_REWRITE, 4, 4, $urandom);
    send_op(OP_LINK, 1, 3000, 32'hF000_0000);
    send_op(OP_REWRITE, 2, 3000, $urandom);
    send_op(OP_LINK, 1, 6, 32'hFFFF_FFFF);
    send_op(OP_REWRITE, 2, 6, $urandom);
    send_op(OP_READ, 1, 6, $urandom);
    send_op(OP_READ, 1, 4095, $urandom);
    send_op(OP_LINK, 1, 2, 32'd0);

    // Smallest table: one data cluster, so the search soon runs dry.
    set_cluster_count(1);
    send_op(OP_ALLOC, 3, $urandom_range(0, 4095), $urandom);
    send_op(OP_ALLOC, 1, $urandom_range(0, 4095), $urandom);
    send_op(OP_READ, 1, 3, $urandom);
    send_op(OP_LINK, 1, 3, $urandom);
    run_random(20, 1'b1);

    set_cluster_count(30);
    run_random(80, 1'b0);
    set_cluster_count(4094);
    run_random(50, 1'b1);
    set_cluster_count(200);
    run_random(80, 1'b0);
    set_cluster_count(12);
    run_random(52, 1'b0);

    drain();
    repeat (50) @(posedge clk);
    if (shadow.expected_q.size() != 0)
      shadow.report_mismatch($sformatf("%0d items never arrived", shadow.expected_q.size()));
    if (shadow.mismatches == 0) begin
      $display("fat_cluster_chain_allocator_unit test passed");
    end else begin
      $display("fat_cluster_chain_allocator_unit test failed");
    end
    $finish;
  end

endmodule
